// File: hw/rtl/gbls_pkg.sv
package gbls_pkg;

  // Width of one endpoint coordinate and of the pixel positions derived from it.
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned PIX_BITS   = COORD_BITS + 1;
  localparam int unsigned POS_BITS   = COORD_BITS + 2;
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;
  localparam int unsigned GRID_BITS  = 7;
  localparam int unsigned PROD_BITS  = COORD_BITS + GRID_BITS;

  // Four endpoint coordinates per load, each divided in turn.
  localparam int unsigned NUM_COORDS = 4;
  localparam int unsigned IDX_BITS   = $clog2(NUM_COORDS);
  localparam int unsigned CNT_BITS   = $clog2(COORD_BITS);

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_BITS  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;

  // Item kinds carried on the input tuser bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_X,
    ST_SETUP
  } gbls_state_e;

endpackage

// File: hw/rtl/grid_bresenham_line_stepper_core.sv
// Grid Bresenham line stepper.
//
// Input stream (s_axis_*): one transfer is either a load (tuser = 0) carrying
// the two line endpoints in pixels, or a step (tuser = 1) asking for the next
// point. Output stream (m_axis_*): one transfer per step while a line is in
// progress, carrying the centre pixel of the next grid cell; tlast marks the
// final point of the line. A step with no line in progress yields nothing.
// The user must write the grid size through cfg_we_i / cfg_wdata_i only while idle;
// the block itself does not enforce it. Zero acts as one.
//
// Timing: a load occupies the block after its transfer through ST_DIV, ST_MUL_X and
// ST_SETUP. A single shared restoring divider produces one quotient bit per cycle for
// each of the four coordinates, then one shared multiplier forms the x and y cell
// centres in ST_MUL_X and ST_SETUP. Steps are accepted one per cycle while the output
// register can take a result; each result appears there the cycle after its step.
//
// Reset leaves the block idle with no line loaded and the grid size at one.
// While the receiver stalls a waiting result, the output register holds it
// and no further item is taken until it has been transferred.
module grid_bresenham_line_stepper_core
  import gbls_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration: grid size in pixels per cell.
  input  logic                     cfg_we_i,
  input  logic [GRID_BITS-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: start_x, start_y, end_x, end_y (lowest bits first).
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // tuser: op.
  input  logic                     s_axis_tuser_i,
  // Output stream.
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata: pixel_x, pixel_y, zero padding (lowest bits first).
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  gbls_state_e state_q, state_d;

  logic [GRID_BITS-1:0]  grid_q;
  logic [GRID_BITS-1:0]  eff_g;
  logic [COORD_BITS-1:0] coord_q [NUM_COORDS];
  logic [COORD_BITS-1:0] cell_q  [NUM_COORDS];

  // Shared divider registers.
  logic [COORD_BITS-1:0] quo_q, quo_d;
  logic [GRID_BITS-1:0]  rem_q, rem_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [GRID_BITS:0]    trial;
  logic                  trial_ge;
  logic [COORD_BITS-1:0] quo_next;
  logic                  cell_we;

  // Shared multiplier.
  logic [COORD_BITS-1:0] mul_cell;
  logic [PROD_BITS-1:0]  centre_full;
  logic [PIX_BITS-1:0]   centre_x_q, centre_x_d;

  // Line state.
  logic [POS_BITS-1:0]   major_pos_q, major_pos_d;
  logic [POS_BITS-1:0]   minor_pos_q, minor_pos_d;
  logic [COORD_BITS-1:0] major_delta_q, major_delta_d;
  logic [COORD_BITS-1:0] minor_delta_q, minor_delta_d;
  logic                  major_neg_q, major_neg_d;
  logic                  minor_neg_q, minor_neg_d;
  logic                  steep_q, steep_d;
  logic [DEC_BITS-1:0]   dec_q, dec_d;
  logic [PIX_BITS-1:0]   steps_left_q, steps_left_d;
  logic                  line_active_q, line_active_d;

  // Setup terms.
  logic                  nx, ny;
  logic [COORD_BITS-1:0] dx, dy;
  logic [POS_BITS-1:0]   g_pos;
  logic [DEC_BITS-1:0]   two_minor, two_major;

  // Output register.
  logic                  m_valid_q, m_valid_d;
  logic [PIX_BITS-1:0]   m_px_q, m_px_d, m_py_q, m_py_d;
  logic                  m_last_q, m_last_d;

  logic in_accept;
  logic emit;

  assign eff_g = (grid_q == '0) ? GRID_BITS'(1) : grid_q;

  // Handshakes: new items only while idle and the output register can take a result.
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign emit            = in_accept && (s_axis_tuser_i == OP_STEP) && line_active_q &&
                           (steps_left_q != '0);

  // One restoring division step: bring down the next dividend bit.
  assign trial    = {rem_q, quo_q[COORD_BITS-1]};
  assign trial_ge = (trial >= {1'b0, eff_g});
  assign quo_next = {quo_q[COORD_BITS-2:0], trial_ge};

  // Cell times grid plus half a cell gives the centre pixel.
  assign mul_cell    = (state_q == ST_MUL_X) ? cell_q[0] : cell_q[1];
  assign centre_full = PROD_BITS'(mul_cell) * PROD_BITS'(eff_g) +
                       PROD_BITS'(eff_g >> 1);

  // Deltas and directions from the four cells.
  assign nx = cell_q[0] > cell_q[2];
  assign ny = cell_q[1] > cell_q[3];
  assign dx = nx ? cell_q[0] - cell_q[2] : cell_q[2] - cell_q[0];
  assign dy = ny ? cell_q[1] - cell_q[3] : cell_q[3] - cell_q[1];
  assign g_pos     = POS_BITS'(eff_g);
  assign two_minor = {2'b00, minor_delta_q, 1'b0};
  assign two_major = {2'b00, major_delta_q, 1'b0};

  // Sequencer: next state, datapath updates and output register.
  always_comb begin
    state_d       = state_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    cell_we       = 1'b0;
    centre_x_d    = centre_x_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    major_neg_d   = major_neg_q;
    minor_neg_d   = minor_neg_q;
    steep_d       = steep_q;
    dec_d         = dec_q;
    steps_left_d  = steps_left_q;
    line_active_d = line_active_q;
    m_valid_d     = m_valid_q && !m_axis_tready_i;
    m_px_d        = m_px_q;
    m_py_d        = m_py_q;
    m_last_d      = m_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser_i == OP_LOAD)) begin
          state_d = ST_DIV;
          quo_d   = s_axis_tdata_i[COORD_BITS-1:0];
          rem_d   = '0;
          cnt_d   = '0;
          idx_d   = '0;
        end else if (in_accept) begin
          if (emit) begin
            m_valid_d = 1'b1;
            m_px_d    = steep_q ? minor_pos_q[PIX_BITS-1:0] : major_pos_q[PIX_BITS-1:0];
            m_py_d    = steep_q ? major_pos_q[PIX_BITS-1:0] : minor_pos_q[PIX_BITS-1:0];
            m_last_d  = (steps_left_q == PIX_BITS'(1));
            major_pos_d = major_neg_q ? major_pos_q - g_pos : major_pos_q + g_pos;
            if (dec_q[DEC_BITS-1]) begin
              dec_d = dec_q + two_minor;
            end else begin
              minor_pos_d = minor_neg_q ? minor_pos_q - g_pos : minor_pos_q + g_pos;
              dec_d       = dec_q + two_minor - two_major;
            end
            steps_left_d  = steps_left_q - PIX_BITS'(1);
            line_active_d = (steps_left_q != PIX_BITS'(1));
          end else begin
            line_active_d = 1'b0;
          end
        end
      end
      ST_DIV: begin
        rem_d = trial_ge ? GRID_BITS'(trial - {1'b0, eff_g}) : trial[GRID_BITS-1:0];
        quo_d = quo_next;
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(COORD_BITS - 1)) begin
          cell_we = 1'b1;
          cnt_d   = '0;
          rem_d   = '0;
          if (idx_q == IDX_BITS'(NUM_COORDS - 1)) begin
            state_d = ST_MUL_X;
          end else begin
            idx_d = idx_q + IDX_BITS'(1);
            quo_d = coord_q[idx_q + IDX_BITS'(1)];
          end
        end
      end
      ST_MUL_X: begin
        centre_x_d = centre_full[PIX_BITS-1:0];
        state_d    = ST_SETUP;
      end
      ST_SETUP: begin
        steep_d = dy > dx;
        if (dy > dx) begin
          major_delta_d = dy;
          minor_delta_d = dx;
          major_pos_d   = {1'b0, centre_full[PIX_BITS-1:0]};
          minor_pos_d   = {1'b0, centre_x_q};
          major_neg_d   = ny;
          minor_neg_d   = nx;
          dec_d         = {2'b00, dx, 1'b0} - {3'b000, dy};
          steps_left_d  = {1'b0, dy} + PIX_BITS'(1);
        end else begin
          major_delta_d = dx;
          minor_delta_d = dy;
          major_pos_d   = {1'b0, centre_x_q};
          minor_pos_d   = {1'b0, centre_full[PIX_BITS-1:0]};
          major_neg_d   = nx;
          minor_neg_d   = ny;
          dec_d         = {2'b00, dy, 1'b0} - {3'b000, dx};
          steps_left_d  = {1'b0, dx} + PIX_BITS'(1);
        end
        line_active_d = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q        <= GRID_BITS'(1);
      line_active_q <= 1'b0;
      steps_left_q  <= '0;
      m_valid_q     <= 1'b0;
      cnt_q         <= '0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
      line_active_q <= line_active_d;
      steps_left_q  <= steps_left_d;
      m_valid_q     <= m_valid_d;
      cnt_q         <= cnt_d;
      idx_q         <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept && (s_axis_tuser_i == OP_LOAD)) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        coord_q[IDX_BITS'(i)] <= s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
      end
    end
    if (cell_we) begin
      cell_q[idx_q] <= quo_next;
    end
    quo_q         <= quo_d;
    rem_q         <= rem_d;
    centre_x_q    <= centre_x_d;
    major_pos_q   <= major_pos_d;
    minor_pos_q   <= minor_pos_d;
    major_delta_q <= major_delta_d;
    minor_delta_q <= minor_delta_d;
    major_neg_q   <= major_neg_d;
    minor_neg_q   <= minor_neg_d;
    steep_q       <= steep_d;
    dec_q         <= dec_d;
    m_px_q        <= m_px_d;
    m_py_q        <= m_py_d;
    m_last_q      <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_BITS - 2 * PIX_BITS)'(0), m_py_q, m_px_q};
  assign m_axis_tlast_o  = m_last_q;

  // A load transfer always starts the divider in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (s_axis_tuser_i == OP_LOAD)) |=> (state_q == ST_DIV))
    else $error("load did not start the divider");

  // The partial remainder stays below the divisor throughout a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < eff_g))
    else $error("divider remainder out of range");

  // An active line always has points left to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (steps_left_q != '0))
    else $error("active line with no points left");

  // Emitting the final point ends the line and flags tlast.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (steps_left_q == PIX_BITS'(1))) |=> (!line_active_q && m_valid_q && m_last_q))
    else $error("final point did not close the line");

  // Items are taken only while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state_q == ST_IDLE))
    else $error("ready raised while busy");

endmodule
